// ----- hw/rtl/q2e_pkg.sv -----
package q2e_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN      = 24;
	localparam int STEP_W       = $clog2(TAB_LEN);
	localparam int VW           = 36;
	localparam int AW           = 32;
	localparam int BW           = 16;
	localparam int THR_W        = 15;
	localparam int LATENCY      = 2 * CORDIC_STEPS + 6;

	localparam logic signed [VW-1:0] Q30_ONE  = VW'(64'sd1073741824);
	localparam logic signed [31:0]   INV_GAIN = 32'sd652032874;
	localparam logic signed [63:0]   CP_ROUND = 64'sd33554432;
	localparam logic [AW-1:0]        HALF_TURN = 32'h8000_0000;
	localparam logic [BW-1:0]        PITCH_UP = 16'h4000;
	localparam logic [BW-1:0]        PITCH_DN = 16'hC000;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic [AW-1:0]        z;
		logic                 zero;
	} cordic_t;

	typedef struct packed {
		logic signed [VW-1:0] m22;
		logic signed [VW-1:0] m21;
		logic signed [VW-1:0] m00;
		logic signed [VW-1:0] m10;
		logic signed [VW-1:0] m11;
		logic signed [VW-1:0] m12g;
		logic signed [VW-1:0] sinp;
	} terms_t;

	typedef struct packed {
		logic [BW-1:0] roll;
		logic [BW-1:0] yawn;
		logic [BW-1:0] yawg;
		logic          sinp_pos;
		logic          lock;
	} side_t;

	function automatic logic [AW-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic [AW-1:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic cordic_t prerot(input logic signed [VW-1:0] x,
	                                   input logic signed [VW-1:0] y);
		cordic_t c;
		c.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			c.x = -x;
			c.y = -y;
			c.z = HALF_TURN;
		end else begin
			c.x = x;
			c.y = y;
			c.z = '0;
		end
		return c;
	endfunction

	function automatic logic [BW-1:0] to_bam(input cordic_t c);
		logic [AW-1:0] s;
		s = c.z + 32'h0000_8000;
		return c.zero ? '0 : s[AW-1:AW-BW];
	endfunction

endpackage

// ----- hw/rtl/q2e_cell.sv -----
module q2e_cell (
	input  logic                  clk,
	input  logic                  en,
	input  logic [q2e_pkg::STEP_W-1:0] step,
	input  q2e_pkg::cordic_t      din,
	output q2e_pkg::cordic_t      dout
);
	import q2e_pkg::*;

	cordic_t nxt;
	cordic_t dout_q;
	logic signed [VW-1:0] dx;
	logic signed [VW-1:0] dy;

	always_comb begin
		dx = din.y >>> step;
		dy = din.x >>> step;
		nxt.zero = din.zero;
		if (din.y >= 0) begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + atan_entry(step);
		end else begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - atan_entry(step);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q <= nxt;
		end
	end

	assign dout = dout_q;

endmodule

// ----- hw/rtl/q2e_terms.sv -----
module q2e_terms (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output q2e_pkg::terms_t    terms
);
	import q2e_pkg::*;

	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [VW-1:0] m00_s2, m10_s2, m20_s2, m11_s2, m12_s2, m21_s2, m22_s2;
	terms_t terms_s3;
	logic signed [VW-1:0] neg_m20;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= 32'(quat_x * quat_x);
			yy_s1 <= 32'(quat_y * quat_y);
			zz_s1 <= 32'(quat_z * quat_z);
			xy_s1 <= 32'(quat_x * quat_y);
			wz_s1 <= 32'(quat_w * quat_z);
			xz_s1 <= 32'(quat_x * quat_z);
			wy_s1 <= 32'(quat_w * quat_y);
			yz_s1 <= 32'(quat_y * quat_z);
			wx_s1 <= 32'(quat_w * quat_x);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m00_s2 <= Q30_ONE - ((VW'(yy_s1) + VW'(zz_s1)) <<< 1);
			m10_s2 <= (VW'(xy_s1) + VW'(wz_s1)) <<< 1;
			m20_s2 <= (VW'(xz_s1) - VW'(wy_s1)) <<< 1;
			m11_s2 <= Q30_ONE - ((VW'(xx_s1) + VW'(zz_s1)) <<< 1);
			m12_s2 <= (VW'(yz_s1) - VW'(wx_s1)) <<< 1;
			m21_s2 <= (VW'(yz_s1) + VW'(wx_s1)) <<< 1;
			m22_s2 <= Q30_ONE - ((VW'(xx_s1) + VW'(yy_s1)) <<< 1);
		end
	end

	assign neg_m20 = -m20_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			terms_s3.m22  <= m22_s2;
			terms_s3.m21  <= m21_s2;
			terms_s3.m00  <= m00_s2;
			terms_s3.m10  <= m10_s2;
			terms_s3.m11  <= m11_s2;
			terms_s3.m12g <= (m20_s2 < 0) ? m12_s2 : -m12_s2;
			if (neg_m20 > Q30_ONE) begin
				terms_s3.sinp <= Q30_ONE;
			end else if (neg_m20 < -Q30_ONE) begin
				terms_s3.sinp <= -Q30_ONE;
			end else begin
				terms_s3.sinp <= neg_m20;
			end
		end
	end

	assign terms = terms_s3;

endmodule

// ----- hw/rtl/quaternion_to_euler_zyx_top.sv -----
// Quaternion (Q1.15) to Z-Y-X Euler angles as 16-bit binary angles (32768 = pi).
// Fully pipelined: one quaternion is accepted per clock while in_stall is low; the
// two CORDIC cell rows run in series (roll/yaw, then pitch from the roll
// magnitude). The pipeline advances whenever the output register is empty or its
// beat is taken, so throughput is one beat per cycle without downstream stall.
// gimbal_threshold (unsigned Q0.15 cos pitch) resets to 0; the user must write it
// only while idle, and the block itself does not enforce this.
module quaternion_to_euler_zyx_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      gimbal_threshold_we,
	input  logic [q2e_pkg::THR_W-1:0] gimbal_threshold,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [15:0]        quat_w,
	input  logic signed [15:0]        quat_x,
	input  logic signed [15:0]        quat_y,
	input  logic signed [15:0]        quat_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [15:0]        roll_angle,
	output logic signed [15:0]        pitch_angle,
	output logic signed [15:0]        yaw_angle,
	output logic                      gimbal_lock
);
	import q2e_pkg::*;

	logic en;
	logic [THR_W-1:0] thr_q;
	logic [LATENCY-1:0] vld_q;
	terms_t terms;

	cordic_t roll_c [CORDIC_STEPS+1];
	cordic_t yawn_c [CORDIC_STEPS+1];
	cordic_t yawg_c [CORDIC_STEPS+1];
	cordic_t pit_c  [CORDIC_STEPS+1];
	logic signed [VW-1:0] sinp_q [CORDIC_STEPS];
	side_t side_q [CORDIC_STEPS];

	logic signed [31:0] magsh;
	logic signed [63:0] prod_q;
	logic signed [VW-1:0] cosp_q;
	logic signed [VW-1:0] sinp_a_q, sinp_b_q;
	logic [BW-1:0] roll_a_q, yawn_a_q, yawg_a_q;
	logic [BW-1:0] roll_b_q, yawn_b_q, yawg_b_q;
	logic signed [VW-1:0] thr_cmp;
	side_t side_in;
	logic [BW-1:0] roll_q, pitch_q, yaw_q;
	logic lock_q;

	assign en       = !vld_q[LATENCY-1] || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (gimbal_threshold_we) begin
			thr_q <= gimbal_threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LATENCY-2:0], in_valid};
		end
	end

	q2e_terms u_terms (
		.clk    (clk),
		.en     (en),
		.quat_w (quat_w),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.terms  (terms)
	);

	assign roll_c[0] = prerot(terms.m22, terms.m21);
	assign yawn_c[0] = prerot(terms.m00, terms.m10);
	assign yawg_c[0] = prerot(terms.m11, terms.m12g);

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_row1
		q2e_cell u_roll (
			.clk(clk), .en(en), .step(STEP_W'(k)), .din(roll_c[k]), .dout(roll_c[k+1])
		);
		q2e_cell u_yawn (
			.clk(clk), .en(en), .step(STEP_W'(k)), .din(yawn_c[k]), .dout(yawn_c[k+1])
		);
		q2e_cell u_yawg (
			.clk(clk), .en(en), .step(STEP_W'(k)), .din(yawg_c[k]), .dout(yawg_c[k+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				sinp_q[k] <= (k == 0) ? terms.sinp : sinp_q[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign magsh = 32'(roll_c[CORDIC_STEPS].x >>> 4);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q   <= magsh * INV_GAIN;
			roll_a_q <= to_bam(roll_c[CORDIC_STEPS]);
			yawn_a_q <= to_bam(yawn_c[CORDIC_STEPS]);
			yawg_a_q <= to_bam(yawg_c[CORDIC_STEPS]);
			sinp_a_q <= sinp_q[CORDIC_STEPS-1];
			cosp_q   <= VW'((prod_q + CP_ROUND) >>> 26);
			roll_b_q <= roll_a_q;
			yawn_b_q <= yawn_a_q;
			yawg_b_q <= yawg_a_q;
			sinp_b_q <= sinp_a_q;
		end
	end

	assign thr_cmp = VW'({thr_q, 15'b0});
	assign pit_c[0] = prerot(cosp_q, sinp_b_q);

	always_comb begin
		side_in.roll     = roll_b_q;
		side_in.yawn     = yawn_b_q;
		side_in.yawg     = yawg_b_q;
		side_in.sinp_pos = sinp_b_q > 0;
		side_in.lock     = !(cosp_q > thr_cmp);
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_row2
		q2e_cell u_pitch (
			.clk(clk), .en(en), .step(STEP_W'(k)), .din(pit_c[k]), .dout(pit_c[k+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				side_q[k] <= (k == 0) ? side_in : side_q[(k == 0) ? 0 : k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_q[CORDIC_STEPS-1].lock) begin
				roll_q  <= '0;
				pitch_q <= side_q[CORDIC_STEPS-1].sinp_pos ? PITCH_UP : PITCH_DN;
				yaw_q   <= side_q[CORDIC_STEPS-1].yawg;
				lock_q  <= 1'b1;
			end else begin
				roll_q  <= side_q[CORDIC_STEPS-1].roll;
				pitch_q <= to_bam(pit_c[CORDIC_STEPS]);
				yaw_q   <= side_q[CORDIC_STEPS-1].yawn;
				lock_q  <= 1'b0;
			end
		end
	end

	assign out_valid   = vld_q[LATENCY-1];
	assign roll_angle  = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle   = yaw_q;
	assign gimbal_lock = lock_q;

endmodule
